// ===== design/rts_pkg.sv =====
package rts_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_REGION = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Register word indexes (byte address = 4 * index).
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_IMAGE_START = 2'd0;
  localparam logic [1:0] REG_IMAGE_END   = 2'd1;
  localparam logic [1:0] REG_ALIGN_BYTES = 2'd2;

  localparam int unsigned ALIGN_W = 17;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 17'd16;

  // Placement window: nothing may end above LIMIT_ADDR.
  localparam logic [31:0] LIMIT_ADDR = 32'hFFF0_0000;
  localparam logic [31:0] MEG_BIT    = 32'h0010_0000;
  localparam logic [31:0] MEG_LOW    = 32'h000F_FFFF;

  typedef struct packed {
    logic        req_type;
    logic [63:0] region_start;
    logic [63:0] region_end;
  } in_word_t;

  typedef struct packed {
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic [31:0] copy_length;
  } out_word_t;

  // Configuration as seen by the datapath, with derived terms precomputed.
  typedef struct packed {
    logic [31:0] image_start;
    logic [31:0] image_end;
    logic [31:0] size;    // image_end - image_start
    logic [31:0] mask;    // align_bytes - 1
    logic [31:0] padded;  // size + mask
  } cfg_t;

endpackage

// ===== design/relocation_target_selector_unit.sv =====
// Channel  | Direction | Handshake                     | Word
// ---------+-----------+-------------------------------+---------------------------
// in       | input     | in_valid / in_stall           | req_type, region_start/end
// out      | output    | out_valid / out_stall         | copy_source/dest/length
// apb      | input     | psel, penable, pwrite, pready | image_start/end, align_bytes
//
// One word per cycle on the input while in_stall is low. A word is registered,
// evaluated in the following cycle and, for a finish, its result lands in the
// output register once that register is free. Reset (rst, synchronous) clears
// the search and restores the register defaults. A held result stalls the input
// only for a staged finish; region words keep flowing past a stalled output.
module relocation_target_selector_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rts_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rts_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rts_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rts_pkg::cfg_t      cfg;
  rts_pkg::in_word_t  s1_data;
  rts_pkg::out_word_t place;
  logic               s1_valid;
  logic               s1_valid_next;
  logic               s1_fire;
  logic               s1_finish;
  logic               in_fire;
  logic               out_free;
  logic               out_valid_next;
  logic [31:0]        best_end;
  logic               best_valid;
  logic [31:0]        cur_best;
  logic               win;
  logic [31:0]        new_end;

  rts_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Until some region wins, the live image end is the bar to beat.
  assign cur_best = best_valid ? best_end : cfg.image_end;

  rts_region_eval u_eval (
    .region_start (s1_data.region_start),
    .region_end   (s1_data.region_end),
    .size         (cfg.size),
    .cur_best     (cur_best),
    .win          (win),
    .new_end      (new_end)
  );

  rts_placement u_place (
    .cfg      (cfg),
    .cur_best (cur_best),
    .result   (place)
  );

  // Handshake. Only a finish needs the output register to be free.
  assign s1_finish = s1_data.req_type == rts_pkg::REQ_FINISH;
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && (!s1_finish || out_free);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_fire) begin
      s1_valid_next = 1'b1;
    end else if (s1_fire) begin
      s1_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (s1_fire && s1_finish) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) s1_data <= in_data;
    if (s1_fire && s1_finish) out_data <= place;
  end

  // Running best; a finish re-arms the search.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_end   <= '0;
    end else if (s1_fire) begin
      if (s1_finish) begin
        best_valid <= 1'b0;
        best_end   <= '0;
      end else if (win) begin
        best_valid <= 1'b1;
        best_end   <= new_end;
      end
    end
  end

  // A result only appears behind a finish that left the input stage.
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_finish))
    else $error("result raised without a finish word");

  // Emitting a placement always re-arms the search.
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_finish) |=> !best_valid)
    else $error("search not re-armed after finish");

  // Input stalls only for a finish blocked by a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_finish && out_valid && out_stall))
    else $error("input stalled without cause");

  // A blocked finish must hold the input off.
  a_hold_off: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_finish && out_valid && out_stall) |-> in_stall)
    else $error("finish overrun by new word");

endmodule

// ===== design/rts_cfg_regs.sv =====
module rts_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rts_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rts_pkg::cfg_t               cfg
);

  logic [31:0]                 image_start;
  logic [31:0]                 image_end;
  logic [rts_pkg::ALIGN_W-1:0] align_bytes;
  logic [31:0]                 size;
  logic [31:0]                 mask;
  logic [31:0]                 padded;

  logic [31:0]                 image_start_next;
  logic [31:0]                 image_end_next;
  logic [rts_pkg::ALIGN_W-1:0] align_bytes_next;
  logic [31:0]                 size_next;
  logic [31:0]                 mask_next;
  logic                        wr;
  logic [1:0]                  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    image_start_next = image_start;
    image_end_next   = image_end;
    align_bytes_next = align_bytes;
    if (wr) begin
      unique case (idx)
        rts_pkg::REG_IMAGE_START: image_start_next = pwdata;
        rts_pkg::REG_IMAGE_END:   image_end_next   = pwdata;
        rts_pkg::REG_ALIGN_BYTES: align_bytes_next = pwdata[rts_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
    // derived terms track the written value so they are ready on the next edge
    size_next = image_end_next - image_start_next;
    mask_next = {{(32-rts_pkg::ALIGN_W){1'b0}}, align_bytes_next} - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_start <= '0;
      image_end   <= '0;
      align_bytes <= rts_pkg::ALIGN_RESET;
      size        <= '0;
      mask        <= {{(32-rts_pkg::ALIGN_W){1'b0}}, rts_pkg::ALIGN_RESET} - 32'd1;
      padded      <= {{(32-rts_pkg::ALIGN_W){1'b0}}, rts_pkg::ALIGN_RESET} - 32'd1;
    end else begin
      image_start <= image_start_next;
      image_end   <= image_end_next;
      align_bytes <= align_bytes_next;
      size        <= size_next;
      mask        <= mask_next;
      padded      <= size_next + mask_next;
    end
  end

  always_comb begin
    unique case (idx)
      rts_pkg::REG_IMAGE_START: prdata = image_start;
      rts_pkg::REG_IMAGE_END:   prdata = image_end;
      rts_pkg::REG_ALIGN_BYTES: prdata = {{(32-rts_pkg::ALIGN_W){1'b0}}, align_bytes};
      default:                  prdata = '0;
    endcase
  end

  assign cfg.image_start = image_start;
  assign cfg.image_end   = image_end;
  assign cfg.size        = size;
  assign cfg.mask        = mask;
  assign cfg.padded      = padded;

endmodule

// ===== design/rts_region_eval.sv =====
module rts_region_eval (
  input  logic [63:0] region_start,
  input  logic [63:0] region_end,
  input  logic [31:0] size,
  input  logic [31:0] cur_best,
  output logic        win,
  output logic [31:0] new_end
);

  logic        start_ok;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] hi_m1;
  logic [31:0] hi_msz;
  logic [31:0] hi_r;
  logic [31:0] room;
  logic [31:0] base;

  always_comb begin
    start_ok = region_start <= {32'd0, rts_pkg::LIMIT_ADDR};
    lo       = region_start[31:0];
    hi       = (region_end > {32'd0, rts_pkg::LIMIT_ADDR}) ? rts_pkg::LIMIT_ADDR
                                                             : region_end[31:0];
    hi_m1    = hi - 32'd1;
    hi_msz   = hi - size;
    hi_r     = hi;
    // pull the end down to a megabyte boundary if hi - 1 or hi - size has MEG_BIT set
    priority if ((hi_m1 & rts_pkg::MEG_BIT) != '0) begin
      if (hi != '0) hi_r = hi_m1 & ~rts_pkg::MEG_LOW;
    end else if ((hi_msz & rts_pkg::MEG_BIT) != '0) begin
      if (hi >= rts_pkg::MEG_BIT) hi_r = (hi - rts_pkg::MEG_BIT) & ~rts_pkg::MEG_LOW;
    end else begin
      hi_r = hi;
    end
    room    = hi_r - lo;
    base    = hi_r - size;
    win     = start_ok && (hi_r >= lo) && (room >= size) && (base > cur_best);
    new_end = hi_r;
  end

endmodule

// ===== design/rts_placement.sv =====
module rts_placement (
  input  rts_pkg::cfg_t     cfg,
  input  logic [31:0]       cur_best,
  output rts_pkg::out_word_t result
);

  logic [31:0] dest0;

  always_comb begin
    dest0              = cur_best - cfg.padded;
    // bring the low bits back in step with the old start
    result.copy_source = cfg.image_start;
    result.copy_dest   = dest0 + ((cfg.image_start - dest0) & cfg.mask);
    result.copy_length = cfg.size;
  end

endmodule
